// File: src/lspg_pkg.sv
// Shared types, constants and helper functions of the LED status pattern generator.
package lspg_pkg;

  localparam int TimeBitsDef = 32;
  localparam int NowW        = 32;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] RegBright   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMedium   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDim      = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCritical = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLow      = 3'd4;
  localparam logic [CfgIdxW-1:0] RegBlink    = 3'd5;
  localparam logic [CfgIdxW-1:0] RegCharge   = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSearch   = 3'd7;

  localparam logic [1:0] LinkDisc   = 2'd0;
  localparam logic [1:0] LinkSearch = 2'd1;
  localparam logic [1:0] LinkConn   = 2'd2;

  localparam int SlotWidth  = 100;
  localparam int SlotCycle  = 10 * SlotWidth;
  localparam int ChunkW     = 10;
  localparam int NumChunks  = (NowW + ChunkW - 1) / ChunkW;
  localparam int PadW       = NumChunks * ChunkW;
  localparam int ResW       = 21;
  localparam int FoldWeight = (1 << ChunkW) % SlotCycle;

  localparam logic [ChunkW-1:0] ChunkWeight [NumChunks] = '{10'd1, 10'd24, 10'd576, 10'd824};

  typedef struct packed {
    logic [7:0] bright_level;
    logic [7:0] medium_level;
    logic [7:0] dim_level;
    logic [6:0] critical_percent;
    logic [6:0] low_percent;
    logic [15:0] blink_interval_ms;
    logic [15:0] charge_step_ms;
    logic [15:0] search_step_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        link_state;
    logic signed [7:0] battery_pct;
    logic              is_charging;
    logic [ResW-1:0]   slot_sum;
  } item_t;

  typedef struct packed {
    logic       drive_write;
    logic [7:0] brightness;
  } res_t;

  typedef struct packed {
    logic [7:0] level;
    logic       rising;
  } breathe_t;

  function automatic logic [ResW-1:0] slot_residue(logic [NowW-1:0] now);
    logic [PadW-1:0] pad;
    logic [ResW-1:0] acc;
    pad = PadW'(now);
    acc = '0;
    for (int k = 0; k < NumChunks; k++) begin
      acc = acc + ResW'(pad[k*ChunkW +: ChunkW]) * ResW'(ChunkWeight[k]);
    end
    return acc;
  endfunction

  function automatic logic slot_on(logic [ResW-1:0] sum);
    logic [ResW-1:0] r;
    r = sum;
    for (int i = 0; i < 3; i++) begin
      r = ResW'(r[ChunkW-1:0]) + ResW'(r[ResW-1:ChunkW]) * ResW'(FoldWeight);
    end
    if (r >= ResW'(SlotCycle)) begin
      r = r - ResW'(SlotCycle);
    end
    return (r < ResW'(2 * SlotWidth)) ||
           ((r >= ResW'(3 * SlotWidth)) && (r < ResW'(5 * SlotWidth)));
  endfunction

  function automatic breathe_t breathe(logic [7:0] level, logic rising, logic [7:0] peak);
    breathe_t b;
    b.level  = level;
    b.rising = rising;
    if (rising) begin
      b.level  = level + 8'd1;
      b.rising = !(b.level >= peak);
    end else if (level == 8'd0) begin
      b.rising = 1'b1;
    end else begin
      b.level = level - 8'd1;
    end
    return b;
  endfunction

endpackage

// File: src/lspg_upd_if.sv
// Update channel: valid/ready handshake with the update item payload.
interface lspg_upd_if;
  logic              valid;
  logic              ready;
  logic [31:0]       now_ms;
  logic [1:0]        link_state;
  logic signed [7:0] battery_pct;
  logic              is_charging;

  modport source (output valid, now_ms, link_state, battery_pct, is_charging, input ready);
  modport sink   (input valid, now_ms, link_state, battery_pct, is_charging, output ready);
endinterface

// File: src/lspg_res_if.sv
// Result channel: valid/ready handshake with the LED write payload.
interface lspg_res_if;
  logic       valid;
  logic       ready;
  logic       drive_write;
  logic [7:0] brightness;

  modport source (output valid, drive_write, brightness, input ready);
  modport sink   (input valid, drive_write, brightness, output ready);
endinterface

// File: src/lspg_cfg.sv
// Configuration register file with reset levels, thresholds and step intervals.
module lspg_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         we_i,
  input  logic [lspg_pkg::CfgIdxW-1:0]  idx_i,
  input  logic [lspg_pkg::CfgDataW-1:0] wdata_i,
  output lspg_pkg::cfg_t               cfg_o
);
  import lspg_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (idx_i)
        RegBright:   cfg_d.bright_level      = wdata_i[7:0];
        RegMedium:   cfg_d.medium_level      = wdata_i[7:0];
        RegDim:      cfg_d.dim_level         = wdata_i[7:0];
        RegCritical: cfg_d.critical_percent  = wdata_i[6:0];
        RegLow:      cfg_d.low_percent       = wdata_i[6:0];
        RegBlink:    cfg_d.blink_interval_ms = wdata_i;
        RegCharge:   cfg_d.charge_step_ms    = wdata_i;
        RegSearch:   cfg_d.search_step_ms    = wdata_i;
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bright_level      <= 8'd255;
      cfg_q.medium_level      <= 8'd128;
      cfg_q.dim_level         <= 8'd32;
      cfg_q.critical_percent  <= 7'd5;
      cfg_q.low_percent       <= 7'd15;
      cfg_q.blink_interval_ms <= 16'd50;
      cfg_q.charge_step_ms    <= 16'd40;
      cfg_q.search_step_ms    <= 16'd30;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: src/lspg_core.sv
// Mode selection, pattern state and result register of the LED status pattern generator.
module lspg_core #(
  parameter int TIME_BITS = lspg_pkg::TimeBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lspg_pkg::cfg_t       cfg_i,
  input  logic                 item_valid_i,
  input  lspg_pkg::item_t      item_i,
  input  logic [TIME_BITS-1:0] now_i,
  output logic                 take_o,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output lspg_pkg::res_t       res_o
);
  import lspg_pkg::*;

  logic [TIME_BITS-1:0] last_q, last_d, elapsed;
  logic                 rising_q, rising_d;
  logic [7:0]           level_q, level_d;
  logic                 res_valid_q;
  res_t                 res_q, res_d;
  logic                 crit, low, charge_mode;
  logic [7:0]           peak;
  breathe_t             br;

  assign take_o      = item_valid_i && (!res_valid_q || res_ready_i);
  assign elapsed     = now_i - last_q;
  assign crit        = !item_i.battery_pct[7] && (item_i.battery_pct[6:0] < cfg_i.critical_percent);
  assign low         = !item_i.battery_pct[7] && (item_i.battery_pct[6:0] < cfg_i.low_percent);
  assign charge_mode = !crit && item_i.is_charging;
  assign peak        = charge_mode ? cfg_i.medium_level : cfg_i.dim_level;
  assign br          = breathe(level_q, rising_q, peak);

  always_comb begin
    res_d    = '0;
    last_d   = last_q;
    rising_d = rising_q;
    level_d  = level_q;
    if (crit) begin
      if (elapsed > TIME_BITS'(cfg_i.blink_interval_ms)) begin
        last_d            = now_i;
        rising_d          = !rising_q;
        res_d.drive_write = 1'b1;
        res_d.brightness  = rising_d ? cfg_i.bright_level : 8'd0;
      end
    end else if (item_i.is_charging) begin
      if (elapsed > TIME_BITS'(cfg_i.charge_step_ms)) begin
        last_d            = now_i;
        level_d           = br.level;
        rising_d          = br.rising;
        res_d.drive_write = 1'b1;
        res_d.brightness  = br.level;
      end
    end else if (low) begin
      res_d.drive_write = 1'b1;
      res_d.brightness  = slot_on(item_i.slot_sum) ? cfg_i.medium_level : 8'd0;
    end else begin
      case (item_i.link_state)
        LinkDisc: begin
          res_d.drive_write = 1'b1;
        end
        LinkSearch: begin
          if (elapsed > TIME_BITS'(cfg_i.search_step_ms)) begin
            last_d            = now_i;
            level_d           = br.level;
            rising_d          = br.rising;
            res_d.drive_write = 1'b1;
            res_d.brightness  = br.level;
          end
        end
        LinkConn: begin
          res_d.drive_write = 1'b1;
          res_d.brightness  = cfg_i.dim_level;
        end
        default: begin
          res_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= '0;
      rising_q    <= 1'b1;
      level_q     <= 8'd0;
      res_valid_q <= 1'b0;
    end else if (take_o) begin
      last_q      <= last_d;
      rising_q    <= rising_d;
      level_q     <= level_d;
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// File: src/led_status_pattern_generator_unit.sv
// Top level of the LED status pattern generator: input register, slot residue, core, config.
//
//   channel  | dir | handshake    | payload
//   upd_i    | in  | valid/ready  | now_ms, link_state, battery_pct, is_charging
//   res_o    | out | valid/ready  | drive_write, brightness
//   cfg      | in  | cfg_we_i     | cfg_idx_i, cfg_wdata_i
//
// One update per cycle while the result channel is not stalled; a transfer loads the input
// register, and when the core takes the item it loads the result register and updates the
// pattern state, so each result is registered in the input register and then the result register.
// Reset clears the pattern state and loads the register defaults; no clearing pass.
// A stalled result holds in the result register; one more update waits in the input
// register, and only then does ready drop.
module led_status_pattern_generator_unit #(
  parameter int TIME_BITS = lspg_pkg::TimeBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lspg_upd_if.sink                      upd_i,
  lspg_res_if.source                    res_o,
  input  logic                          cfg_we_i,
  input  logic [lspg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lspg_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import lspg_pkg::*;

  localparam logic [NowW-1:0] NowMask =
    (TIME_BITS >= NowW) ? {NowW{1'b1}} : NowW'((64'd1 << TIME_BITS) - 64'd1);

  cfg_t                 cfg;
  logic                 item_valid_q;
  item_t                item_q, item_d;
  logic [TIME_BITS-1:0] now_q;
  logic [NowW-1:0]      now_m;
  logic                 take;
  res_t                 res;

  assign now_m       = upd_i.now_ms & NowMask;
  assign upd_i.ready = !item_valid_q || take;

  always_comb begin
    item_d.link_state  = upd_i.link_state;
    item_d.battery_pct = upd_i.battery_pct;
    item_d.is_charging = upd_i.is_charging;
    item_d.slot_sum    = slot_residue(now_m);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (upd_i.valid && upd_i.ready) begin
      item_valid_q <= 1'b1;
    end else if (take) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i.valid && upd_i.ready) begin
      item_q <= item_d;
      now_q  <= TIME_BITS'(now_m);
    end
  end

  lspg_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  lspg_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (item_valid_q),
    .item_i       (item_q),
    .now_i        (now_q),
    .take_o       (take),
    .res_valid_o  (res_o.valid),
    .res_ready_i  (res_o.ready),
    .res_o        (res)
  );

  assign res_o.drive_write = res.drive_write;
  assign res_o.brightness  = res.brightness;

endmodule

// File: src/lspg_checker.sv
// Port-level assertions for the LED status pattern generator, bound to the top level.
module lspg_port_assert (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       upd_valid_i,
  input logic       upd_ready_i,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic       drive_write_i,
  input logic [7:0] brightness_i
);

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result dropped while stalled");

  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(drive_write_i) && $stable(brightness_i))
    else $error("result payload changed while stalled");

  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !upd_ready_i |-> res_valid_i && !res_ready_i)
    else $error("update ready low without a stalled result");

  a_no_write_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !drive_write_i |-> brightness_i == 8'd0)
    else $error("brightness set on a result without a write");

endmodule

bind led_status_pattern_generator_unit lspg_port_assert u_lspg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .upd_valid_i   (upd_i.valid),
  .upd_ready_i   (upd_i.ready),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .drive_write_i (res_o.drive_write),
  .brightness_i  (res_o.brightness)
);

// File: verif/lspg_checker.sv
`timescale 1ns / 1ps
// Checker for the LED status pattern generator: watches both channels and the register port, predicts each LED write and compares.
module lspg_checker
  import lspg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  lspg_upd_if                 upd_i,
  lspg_res_if                 res_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output int                  errors_o,
  output int                  pending_o,
  output int                  updates_o,
  output int                  results_o,
  output int                  writes_o,
  output logic [6:0]          modes_o
);

  typedef enum logic [2:0] {
    ModeCritical, ModeCharge, ModeLow, ModeOff, ModeSearch, ModeSteady, ModeUnused
  } led_mode_e;

  cfg_t        regs;
  logic [31:0] step_stamp;
  logic        ramp_up;
  logic [7:0]  ramp_level;
  res_t        led_due [$];
  int          errors, updates, results, writes;
  logic [6:0]  modes_seen;

  task automatic advance_ramp(input logic [7:0] peak);
    if (ramp_up) begin
      ramp_level = ramp_level + 8'd1;
      if (ramp_level >= peak) ramp_up = 1'b0;
    end else if (ramp_level == 8'd0) begin
      ramp_up = 1'b1;
    end else begin
      ramp_level = ramp_level - 8'd1;
    end
  endtask

  task automatic predict_led(input logic [31:0] now, input logic [1:0] link,
                             input logic signed [7:0] pct, input logic chg,
                             output res_t led, output led_mode_e mode);
    logic [31:0] elapsed;
    logic        known;
    int          slot;
    known   = !pct[7];
    elapsed = now - step_stamp;
    slot    = int'((now / 32'd100) % 32'd10);
    led     = '0;
    if (known && pct[6:0] < regs.critical_percent) begin
      mode = ModeCritical;
      if (elapsed > {16'd0, regs.blink_interval_ms}) begin
        step_stamp      = now;
        ramp_up         = !ramp_up;
        led.drive_write = 1'b1;
        led.brightness  = ramp_up ? regs.bright_level : 8'd0;
      end
    end else if (chg) begin
      mode = ModeCharge;
      if (elapsed > {16'd0, regs.charge_step_ms}) begin
        step_stamp = now;
        advance_ramp(regs.medium_level);
        led.drive_write = 1'b1;
        led.brightness  = ramp_level;
      end
    end else if (known && pct[6:0] < regs.low_percent) begin
      mode            = ModeLow;
      led.drive_write = 1'b1;
      led.brightness  = (slot == 0 || slot == 1 || slot == 3 || slot == 4) ?
                        regs.medium_level : 8'd0;
    end else if (link == LinkDisc) begin
      mode            = ModeOff;
      led.drive_write = 1'b1;
    end else if (link == LinkSearch) begin
      mode = ModeSearch;
      if (elapsed > {16'd0, regs.search_step_ms}) begin
        step_stamp = now;
        advance_ramp(regs.dim_level);
        led.drive_write = 1'b1;
        led.brightness  = ramp_level;
      end
    end else if (link == LinkConn) begin
      mode            = ModeSteady;
      led.drive_write = 1'b1;
      led.brightness  = regs.dim_level;
    end else begin
      mode = ModeUnused;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    res_t      want;
    res_t      led;
    led_mode_e mode;
    if (!rst_ni) begin
      regs.bright_level      = 8'd255;
      regs.medium_level      = 8'd128;
      regs.dim_level         = 8'd32;
      regs.critical_percent  = 7'd5;
      regs.low_percent       = 7'd15;
      regs.blink_interval_ms = 16'd50;
      regs.charge_step_ms    = 16'd40;
      regs.search_step_ms    = 16'd30;
      step_stamp             = '0;
      ramp_up                = 1'b1;
      ramp_level             = '0;
      led_due.delete();
    end else begin
      if (res_i.valid && res_i.ready) begin
        results++;
        if (led_due.size() == 0) begin
          $display("%0t: result with nothing expected: actual write %0b brightness %0d",
                   $time, res_i.drive_write, res_i.brightness);
          errors++;
        end else begin
          want = led_due.pop_front();
          if (res_i.drive_write !== want.drive_write) begin
            $display("%0t: drive_write mismatch: expected %0b, actual %0b",
                     $time, want.drive_write, res_i.drive_write);
            errors++;
          end
          if (res_i.brightness !== want.brightness) begin
            $display("%0t: brightness mismatch: expected %0d, actual %0d",
                     $time, want.brightness, res_i.brightness);
            errors++;
          end
        end
      end
      if (upd_i.valid && upd_i.ready) begin
        predict_led(upd_i.now_ms, upd_i.link_state, upd_i.battery_pct, upd_i.is_charging,
                    led, mode);
        led_due.push_back(led);
        updates++;
        if (led.drive_write) writes++;
        modes_seen[mode] = 1'b1;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegBright:   regs.bright_level      = cfg_wdata_i[7:0];
          RegMedium:   regs.medium_level      = cfg_wdata_i[7:0];
          RegDim:      regs.dim_level         = cfg_wdata_i[7:0];
          RegCritical: regs.critical_percent  = cfg_wdata_i[6:0];
          RegLow:      regs.low_percent       = cfg_wdata_i[6:0];
          RegBlink:    regs.blink_interval_ms = cfg_wdata_i;
          RegCharge:   regs.charge_step_ms    = cfg_wdata_i;
          RegSearch:   regs.search_step_ms    = cfg_wdata_i;
          default: ;
        endcase
      end
    end
    errors_o  <= errors;
    pending_o <= led_due.size();
    updates_o <= updates;
    results_o <= results;
    writes_o  <= writes;
    modes_o   <= modes_seen;
  end

  initial begin
    errors     = 0;
    updates    = 0;
    results    = 0;
    writes     = 0;
    modes_seen = '0;
  end

endmodule

// File: verif/led_status_pattern_generator_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for the LED status pattern generator: clock, reset, update and register stimulus, verdict.
module led_status_pattern_generator_unit_tb;
  import lspg_pkg::*;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;
  logic                quiet;
  int                  chk_errors, chk_pending, chk_updates, chk_results, chk_writes;
  logic [6:0]          chk_modes;

  lspg_upd_if upd ();
  lspg_res_if res ();

  led_status_pattern_generator_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .upd_i       (upd),
    .res_o       (res),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  lspg_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .upd_i       (upd),
    .res_i       (res),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .errors_o    (chk_errors),
    .pending_o   (chk_pending),
    .updates_o   (chk_updates),
    .results_o   (chk_results),
    .writes_o    (chk_writes),
    .modes_o     (chk_modes)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  always @(posedge clk_i) begin
    res.ready <= quiet || ($urandom_range(99) >= 7);
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_update(input logic [31:0] now, input logic [1:0] link,
                             input logic signed [7:0] pct, input logic chg);
    upd.valid       <= 1'b1;
    upd.now_ms      <= now;
    upd.link_state  <= link;
    upd.battery_pct <= pct;
    upd.is_charging <= chg;
    @(posedge clk_i);
    while (!upd.ready) @(posedge clk_i);
    if (!quiet && $urandom_range(99) < 7) begin
      upd.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    upd.valid <= 1'b0;
    @(posedge clk_i);
    while (chk_pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
  endtask

  task automatic load_registers(input cfg_t c);
    write_reg(RegBright,   {8'($urandom()), c.bright_level});
    write_reg(RegMedium,   {8'($urandom()), c.medium_level});
    write_reg(RegDim,      {8'($urandom()), c.dim_level});
    write_reg(RegCritical, {9'($urandom()), c.critical_percent});
    write_reg(RegLow,      {9'($urandom()), c.low_percent});
    write_reg(RegBlink,    c.blink_interval_ms);
    write_reg(RegCharge,   c.charge_step_ms);
    write_reg(RegSearch,   c.search_step_ms);
    cfg_we <= 1'b0;
  endtask

  function automatic cfg_t pick_settings(input int kind);
    cfg_t c;
    case (kind)
      0: begin
        c = '{8'd255, 8'd128, 8'd32, 7'd5, 7'd15, 16'd50, 16'd40, 16'd30};
      end
      1: begin
        c = '0;
      end
      2: begin
        c = '{8'd255, 8'd255, 8'd255, 7'd127, 7'd127, 16'hFFFF, 16'hFFFF, 16'hFFFF};
      end
      default: begin
        c.bright_level      = 8'($urandom());
        c.medium_level      = 8'($urandom_range(0, 60));
        c.dim_level         = 8'($urandom_range(0, 40));
        c.critical_percent  = 7'($urandom_range(0, 40));
        c.low_percent       = 7'($urandom_range(0, 110));
        c.blink_interval_ms = 16'($urandom_range(0, 120));
        c.charge_step_ms    = 16'($urandom_range(0, 120));
        c.search_step_ms    = 16'($urandom_range(0, 120));
      end
    endcase
    return c;
  endfunction

  initial begin
    cfg_t              c;
    logic [31:0]       clock_ms;
    logic [1:0]        run_link;
    logic signed [7:0] run_pct;
    logic              run_chg;
    int                span, run_left, pick, settings;
    upd.valid       = 1'b0;
    upd.now_ms      = '0;
    upd.link_state  = LinkDisc;
    upd.battery_pct = '0;
    upd.is_charging = 1'b0;
    res.ready       = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = RegBright;
    cfg_wdata       = '0;
    quiet           = 1'b0;
    rst_ni          = 1'b0;
    settings        = 1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset register values: each mode, slot edges, time wrap, priority
    send_update(32'd0,          LinkConn,   8'sd50,   1'b0);
    send_update(32'd0,          LinkDisc,   -8'sd1,   1'b0);
    send_update(32'd10,         2'd3,       -8'sd128, 1'b0);
    send_update(32'd31,         LinkSearch, 8'sd127,  1'b0);
    send_update(32'd62,         LinkSearch, 8'sd100,  1'b0);
    send_update(32'd100,        LinkConn,   8'sd100,  1'b1);
    send_update(32'd200,        LinkDisc,   8'sd20,   1'b1);
    send_update(32'd99,         LinkConn,   8'sd14,   1'b0);
    send_update(32'd100,        LinkConn,   8'sd14,   1'b0);
    send_update(32'd250,        LinkSearch, 8'sd14,   1'b0);
    send_update(32'd300,        LinkDisc,   8'sd14,   1'b0);
    send_update(32'd499,        LinkConn,   8'sd5,    1'b0);
    send_update(32'd500,        LinkConn,   8'sd14,   1'b0);
    send_update(32'd999,        LinkConn,   8'sd14,   1'b0);
    send_update(32'd1000,       LinkConn,   8'sd14,   1'b0);
    send_update(32'hFFFF_FFFF,  2'd3,       8'sd14,   1'b0);
    send_update(32'd1000,       LinkConn,   8'sd0,    1'b1);
    send_update(32'd1050,       LinkConn,   8'sd0,    1'b0);
    send_update(32'd1051,       LinkSearch, 8'sd4,    1'b1);
    send_update(32'hFFFF_FFF0,  LinkDisc,   8'sd4,    1'b0);
    send_update(32'd5,          LinkConn,   8'sd0,    1'b0);
    send_update(32'd64,         LinkConn,   8'sd0,    1'b0);
    send_update(32'd65,         LinkConn,   8'sd15,   1'b0);
    send_update(32'd66,         2'd3,       8'sd15,   1'b0);
    drain_results();

    clock_ms = 32'd2000;
    for (int phase = 0; phase < 6; phase++) begin
      c = pick_settings(phase);
      load_registers(c);
      settings++;
      span = int'(c.blink_interval_ms);
      if (c.charge_step_ms > span) span = int'(c.charge_step_ms);
      if (c.search_step_ms > span) span = int'(c.search_step_ms);
      span = span + 20;
      if (phase == 4) clock_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, 3000));
      run_left = 0;
      for (int n = 0; n < 150; n++) begin
        if (phase == 3 && n == 20) quiet <= 1'b1;
        if (phase == 3 && n == 110) quiet <= 1'b0;
        if (run_left == 0) begin
          run_left = $urandom_range(5, 40);
          run_link = 2'($urandom_range(0, 3));
          run_chg  = ($urandom_range(99) < 30);
          pick     = $urandom_range(3);
          case (pick)
            0: run_pct = 8'($urandom_range(0, int'(c.critical_percent)));
            1: run_pct = 8'($urandom_range(int'(c.critical_percent), int'(c.low_percent)));
            2: run_pct = 8'($urandom_range(int'(c.low_percent), 127));
            default: run_pct = -8'($urandom_range(1, 128));
          endcase
        end
        run_left--;
        pick = $urandom_range(99);
        if (pick < 5) clock_ms = $urandom();
        else if (pick >= 10) clock_ms = clock_ms + 32'($urandom_range(0, span));
        if ($urandom_range(99) < 10) begin
          send_update(clock_ms, 2'($urandom()), 8'($urandom()), 1'($urandom()));
        end else begin
          send_update(clock_ms, run_link, run_pct, run_chg);
        end
      end
      drain_results();
    end

    $display("Run covered %0d updates and %0d results (%0d LED writes) over %0d settings",
             chk_updates, chk_results, chk_writes, settings);
    $display("Pattern modes reached (unused link down to critical): %b", chk_modes);
    if (chk_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: led_status_pattern_generator_unit.f
src/lspg_pkg.sv
src/lspg_upd_if.sv
src/lspg_res_if.sv
src/lspg_cfg.sv
src/lspg_core.sv
src/led_status_pattern_generator_unit.sv
src/lspg_checker.sv
verif/lspg_checker.sv
verif/led_status_pattern_generator_unit_tb.sv
